// ----- src/aes128_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 package
// Shared types, S-box tables and GF(2^8) helpers.
// ----------------------------------------------------------------------------
package aes128_pkg;

    localparam int ROUNDS_DEF = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef struct packed {
        logic        command;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXP_RD,
        ST_EXP_WR,
        ST_INIT,
        ST_ROUND,
        ST_DONE
    } t_state;

    localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] SBOX_REV [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    localparam logic [7:0] RCON [11] = '{
        8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Forward mix of one column, a0 on top.
    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    endfunction

    // Inverse mix: precondition with {05,00,04,00} then forward mix.
    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3, u, v;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        u = xt(xt(a0 ^ a2));
        v = xt(xt(a1 ^ a3));
        return mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
    endfunction

endpackage

// ----- src/aes128_block_cipher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block cipher
// FIPS-197 encrypt/decrypt of one 128-bit block, round keys held in a RAM.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | beat
//  in      | input     | i_valid / o_ready  | t_in_beat  (command, block)
//  out     | output    | o_valid / i_ready  | t_out_beat (result)
//  cfg     | input     | i_cfg_we           | index + 64-bit key half
//
// Steps per beat with valid keys: accept, initial key add, ten rounds on one
// shared round unit, then load of the result register. The first beat after
// reset or a key write first runs the expansion, which writes the 44 round-key
// words into the key RAM, each word a write state plus a spacer state.
// The key RAM has a registered read; each round fetches its four words at
// once as a 128-bit row, so the RAM is 11 rows x 128 bits, words written
// one 32-bit lane at a time.
// Reset clears the FSM, the key-valid flag and the key registers; the RAM
// is not cleared. A result stays on o_valid until i_ready; the next beat is
// accepted while it waits, and a finished block holds in the core until the
// result register is free.
// ----------------------------------------------------------------------------
module aes128_block_cipher
    import aes128_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in_beat              i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out_beat             o_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NROWS = ROUNDS + 1;
    localparam int NWORDS = 4 * NROWS;
    localparam int RW = $clog2(NROWS);
    localparam int WW = $clog2(NWORDS + 1);

    // key RAM: row r holds words 4r..4r+3, word 4r in bits 127:96
    logic [127:0] r_ram [NROWS];
    logic [127:0] r_rd;

    logic [63:0]  r_key_high, r_key_low;
    logic         r_keys_valid;
    t_state       r_state, n_state;
    logic [WW-1:0] r_widx, n_widx;     // expansion word index
    logic [RW-1:0] r_rnd, n_rnd;       // rounds done
    logic          r_dec, n_dec;
    logic [127:0]  r_st, n_st;
    logic          r_oval, n_oval;
    t_out_beat     r_out, n_out;       // result register
    logic [127:0]  r_prev, n_prev;     // last four words during expansion

    logic          ram_we;
    logic [RW-1:0] ram_wrow, ram_rrow;
    logic [1:0]    ram_lane;
    logic [31:0]   ram_wd;

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_ram[ram_wrow][(3 - ram_lane) * 32 +: 32] <= ram_wd;
        end
        r_rd <= r_ram[ram_rrow];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high   <= '0;
            r_key_low    <= '0;
            r_keys_valid <= 1'b0;
            r_state      <= ST_IDLE;
            r_oval       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
            if (r_state == ST_INIT && r_widx != '0) begin
                r_keys_valid <= 1'b1;
            end
            if (i_cfg_we && i_cfg_idx == REG_KEY_HIGH) begin
                r_key_high   <= i_cfg_data;
                r_keys_valid <= 1'b0;
            end else if (i_cfg_we && i_cfg_idx == REG_KEY_LOW) begin
                r_key_low    <= i_cfg_data;
                r_keys_valid <= 1'b0;
            end
        end
        r_widx <= n_widx;
        r_rnd  <= n_rnd;
        r_dec  <= n_dec;
        r_st   <= n_st;
        r_out  <= n_out;
        r_prev <= n_prev;
    end

    // ---- round datapath (byte i of state = bits 127-8i) ----
    logic [127:0] sb, sr, mx, fwd_out, inv_out, inv_sr, inv_sb, ark;
    logic         last;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            sb[127 - 8*i -: 8] = SBOX[r_st[127 - 8*i -: 8]];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sr[127 - 8*(c*4+r) -: 8] = sb[127 - 8*(((c + r) % 4)*4 + r) -: 8];
                inv_sr[127 - 8*(((c + r) % 4)*4 + r) -: 8] = r_st[127 - 8*(c*4+r) -: 8];
            end
        end
        for (int i = 0; i < 16; i++) begin
            inv_sb[127 - 8*i -: 8] = SBOX_REV[inv_sr[127 - 8*i -: 8]];
        end
        last = (r_rnd == RW'(ROUNDS - 1));
        for (int c = 0; c < 4; c++) begin
            mx[127 - 32*c -: 32] = mix_col(sr[127 - 32*c -: 32]);
        end
        fwd_out = (last ? sr : mx) ^ r_rd;
        ark = inv_sb ^ r_rd;
        for (int c = 0; c < 4; c++) begin
            inv_out[127 - 32*c -: 32] = last ? ark[127 - 32*c -: 32]
                                             : inv_mix_col(ark[127 - 32*c -: 32]);
        end
    end

    // ---- expansion word ----
    logic [31:0] t_w, rot, new_w;
    logic [RW-1:0] exp_row;
    always_comb begin
        exp_row = RW'(r_widx >> 2);
        t_w = r_prev[31:0];
        rot = {t_w[23:0], t_w[31:24]};
        if (r_widx[1:0] == 2'd0) begin
            new_w = {SBOX[rot[31:24]] ^ RCON[exp_row], SBOX[rot[23:16]],
                     SBOX[rot[15:8]], SBOX[rot[7:0]]} ^ r_prev[127:96];
        end else begin
            new_w = t_w ^ r_prev[127:96];
        end
    end

    // ---- control ----
    always_comb begin
        n_state  = r_state;
        n_widx   = r_widx;
        n_rnd    = r_rnd;
        n_dec    = r_dec;
        n_st     = r_st;
        n_oval   = r_oval;
        n_out    = r_out;
        n_prev   = r_prev;
        ram_we   = 1'b0;
        ram_wrow = exp_row;
        ram_lane = r_widx[1:0];
        ram_wd   = new_w;
        ram_rrow = '0;
        o_ready  = 1'b0;

        if (r_oval && i_ready) begin
            n_oval = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_dec = i_data.command;
                    n_st  = {i_data.block_high, i_data.block_low};
                    n_rnd = '0;
                    n_widx = '0;
                    if (r_keys_valid) begin
                        n_state = ST_INIT;
                    end else begin
                        n_prev  = {r_key_high, r_key_low};
                        n_state = ST_EXP_WR;
                    end
                end
                ram_rrow = i_data.command ? RW'(ROUNDS) : '0;
            end
            ST_EXP_RD: begin
                // spacer; after the last word it also fetches the first round key
                if (r_widx == WW'(NWORDS)) begin
                    n_state  = ST_INIT;
                    ram_rrow = r_dec ? RW'(ROUNDS) : '0;
                end else begin
                    n_state = ST_EXP_WR;
                end
            end
            ST_EXP_WR: begin
                // words 0..3 come straight from the key, then derived words
                ram_we = 1'b1;
                if (r_widx < WW'(4)) begin
                    ram_wd = r_prev[127:96];
                    n_prev = {r_prev[95:0], r_prev[127:96]};
                end else begin
                    n_prev = {r_prev[95:0], new_w};
                end
                n_widx  = r_widx + WW'(1);
                n_state = ST_EXP_RD;
            end
            ST_INIT: begin
                // r_rd holds round key 0 (enc) or ROUNDS (dec)
                n_st     = r_st ^ r_rd;
                n_state  = ST_ROUND;
                n_widx   = '0;
                ram_rrow = r_dec ? RW'(ROUNDS - 1) : RW'(1);
            end
            ST_ROUND: begin
                n_st = r_dec ? inv_out : fwd_out;
                n_rnd = r_rnd + RW'(1);
                ram_rrow = r_dec ? RW'(ROUNDS - 2) - r_rnd : r_rnd + RW'(2);
                if (last) begin
                    ram_rrow = '0;
                    n_state  = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait here while the result register still holds an unread beat
                if (!r_oval || i_ready) begin
                    n_oval  = 1'b1;
                    n_out   = r_st;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_valid = r_oval;
    assign o_data  = r_out;

    // ---- checks ----
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready)
        else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("result dropped");
    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_rnd < RW'(ROUNDS)))
        else $error("round overrun");
    a_keys_before_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> r_keys_valid || $past(i_cfg_we))
        else $error("round without keys");

endmodule
